@@ design/drk_pkg.sv @@
// Package for the distance rank keeper: command codes and field widths.
// No dependencies.
`default_nettype none
package drk_pkg;
    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_INSERT = 2'd1;
    localparam logic [1:0] KIND_SETD   = 2'd2;
    localparam logic [1:0] KIND_EMIT   = 2'd3;
    localparam int ID_W   = 5;
    localparam int DIST_W = 16;
    localparam int ID_SLOTS = 32;
    typedef logic [ID_W-1:0]   id_t;
    typedef logic [DIST_W-1:0] dist_t;
endpackage
`default_nettype wire

@@ design/distance_rank_keeper.sv @@
// Distance rank keeper top: sorted table; clear, insert, set distance, repair, emit.
// Depends on drk_pkg.
`default_nettype none
// Keeps up to min(MAX_ENTRIES,32) entries in ascending distance order. One
// command word is taken at a time; s_tready is low while it is processed. A
// shared compare/step unit walks the table one rank per cycle, save where emit
// waits on m_tready. Insert locates the id, finds the rank, shifts and places;
// set distance locates the id and writes. Repair moves each entry forward by
// swaps, then backward where it did not move forward. Emit then sends one
// output word per entry as m_tready takes them.
module distance_rank_keeper #(
    parameter int MAX_ENTRIES = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // tdata: entry_id[4:0], distance[20:5], team[21], zero pad [23:22]
    input  wire logic [23:0] s_tdata,
    // tuser: kind[1:0]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // tdata: rank[4:0], ranked_id[9:5], team_rank[14:10], ranked_distance[30:15],
    // order_changed[31]
    output logic [31:0]      m_tdata,
    // tuser: ranked_team
    output logic             m_tuser,
    output logic             m_tlast
);
    import drk_pkg::*;

    localparam int CAP = (MAX_ENTRIES < ID_SLOTS) ? MAX_ENTRIES : ID_SLOTS;
    localparam int CW  = $clog2(ID_SLOTS + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAP);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_LOCATE = 4'd1;
    localparam logic [3:0] ST_FIND   = 4'd2;
    localparam logic [3:0] ST_SHIFT  = 4'd3;
    localparam logic [3:0] ST_PLACE  = 4'd4;
    localparam logic [3:0] ST_RI     = 4'd5;
    localparam logic [3:0] ST_FWD    = 4'd6;
    localparam logic [3:0] ST_BWD    = 4'd7;
    localparam logic [3:0] ST_EMIT   = 4'd8;
    localparam logic [3:0] ST_OUT    = 4'd9;

    id_t   order_mem [ID_SLOTS];
    dist_t dist_mem  [ID_SLOTS];
    logic  team_mem  [ID_SLOTS];

    logic [3:0]    state_reg;
    logic [CW-1:0] count_reg;
    logic          changed_reg;
    logic [1:0]    kind_reg;
    id_t           id_reg;
    dist_t         d_reg;
    logic          tm_reg;
    logic [CW-1:0] k_reg, at_reg, i_reg, j_reg;
    logic          moved_reg;
    logic [4:0]    seen0_reg, seen1_reg;
    logic          ov_reg;
    logic [31:0]   od_reg;
    logic          ot_reg, ol_reg;

    id_t   ok, okm1;
    dist_t dk, dkm1;
    logic  out_load;
    assign ok   = order_mem[k_reg[4:0]];
    assign okm1 = order_mem[5'(k_reg - 1'b1)];
    assign dk   = dist_mem[ok];
    assign dkm1 = dist_mem[okm1];
    assign out_load = (state_reg == ST_EMIT) && (k_reg < count_reg) && (!ov_reg || m_tready);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = ov_reg;
    assign m_tdata  = od_reg;
    assign m_tuser  = ot_reg;
    assign m_tlast  = ol_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_PLACE)
        begin
            order_mem[at_reg[4:0]] <= id_reg;
            dist_mem[id_reg]       <= d_reg;
            team_mem[id_reg]       <= tm_reg;
        end
        else if (state_reg == ST_SHIFT && k_reg > at_reg)
            order_mem[k_reg[4:0]] <= okm1;
        else if (state_reg == ST_LOCATE && kind_reg == KIND_SETD && k_reg < count_reg
                 && ok == id_reg)
            dist_mem[id_reg] <= d_reg;
        else if ((state_reg == ST_FWD && moved_reg && k_reg < count_reg && d_reg > dk) ||
                 (state_reg == ST_BWD && k_reg != '0 && d_reg < dkm1))
        begin
            order_mem[k_reg[4:0]]         <= okm1;
            order_mem[5'(k_reg - 1'b1)]   <= ok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            changed_reg <= 1'b0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            if (out_load)
                ov_reg <= 1'b1;
            else if (ov_reg && m_tready)
                ov_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        kind_reg <= s_tuser;
                        id_reg   <= s_tdata[4:0];
                        d_reg    <= s_tdata[20:5];
                        tm_reg   <= s_tdata[21];
                        k_reg    <= '0;
                        case (s_tuser)
                            KIND_CLEAR:  count_reg <= '0;
                            KIND_INSERT: state_reg <= (count_reg >= CAP_C) ? ST_IDLE
                                                                           : ST_LOCATE;
                            KIND_SETD:   state_reg <= ST_LOCATE;
                            default:
                            begin
                                i_reg     <= '0;
                                state_reg <= ST_RI;
                            end
                        endcase
                    end
                end
                ST_LOCATE:
                begin
                    if (k_reg >= count_reg)
                    begin
                        k_reg     <= '0;
                        at_reg    <= count_reg;
                        state_reg <= (kind_reg == KIND_INSERT) ? ST_FIND : ST_IDLE;
                    end
                    else if (ok == id_reg)
                        state_reg <= ST_IDLE;
                    else
                        k_reg <= k_reg + 1'b1;
                end
                ST_FIND:
                begin
                    if (k_reg >= count_reg || d_reg <= dk)
                    begin
                        at_reg    <= k_reg;
                        k_reg     <= count_reg;
                        state_reg <= ST_SHIFT;
                    end
                    else
                        k_reg <= k_reg + 1'b1;
                end
                ST_SHIFT:
                begin
                    if (k_reg > at_reg)
                        k_reg <= k_reg - 1'b1;
                    else
                        state_reg <= ST_PLACE;
                end
                ST_PLACE:
                begin
                    count_reg   <= count_reg + 1'b1;
                    changed_reg <= 1'b1;
                    state_reg   <= ST_IDLE;
                end
                ST_RI:
                begin
                    if (i_reg >= count_reg)
                    begin
                        k_reg     <= '0;
                        seen0_reg <= '0;
                        seen1_reg <= '0;
                        state_reg <= ST_EMIT;
                    end
                    else
                    begin
                        k_reg     <= i_reg;
                        moved_reg <= 1'b0;
                        state_reg <= ST_FWD;
                    end
                end
                ST_FWD:
                begin
                    // d_reg holds the entry's distance; compare it with the one at k_reg, next after it
                    if (k_reg == i_reg && !moved_reg && k_reg == i_reg)
                        d_reg <= dk;
                    if (k_reg == i_reg && !moved_reg)
                    begin
                        moved_reg <= 1'b1;
                        k_reg     <= k_reg + 1'b1;
                    end
                    else if (k_reg < count_reg && d_reg > dk)
                    begin
                        changed_reg <= 1'b1;
                        at_reg      <= k_reg;
                        k_reg       <= k_reg + 1'b1;
                    end
                    else if (at_reg == i_reg)
                        begin
                            k_reg     <= i_reg;
                            state_reg <= ST_BWD;
                        end
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= ST_RI;
                    end
                end
                ST_BWD:
                begin
                    if (k_reg != '0 && d_reg < dkm1)
                    begin
                        changed_reg <= 1'b1;
                        k_reg       <= k_reg - 1'b1;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= ST_RI;
                    end
                end
                ST_EMIT:
                begin
                    if (k_reg >= count_reg)
                    begin
                        changed_reg <= 1'b0;
                        state_reg   <= ST_IDLE;
                    end
                    else if (out_load)
                    begin
                        od_reg <= {changed_reg, dk,
                                   team_mem[ok] ? seen1_reg : seen0_reg, ok, k_reg[4:0]};
                        ot_reg <= team_mem[ok];
                        ol_reg <= (k_reg + 1'b1 == count_reg);
                        if (team_mem[ok])
                            seen1_reg <= seen1_reg + 1'b1;
                        else
                            seen0_reg <= seen0_reg + 1'b1;
                        k_reg <= k_reg + 1'b1;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
            if (state_reg == ST_RI && i_reg < count_reg)
                at_reg <= i_reg;
        end
    end
endmodule
`default_nettype wire
